// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/rmpr_pkg.sv -----
// ----------------------------------------------------------------------------
// rmpr_pkg
// Widths, register indexes and the duty slew helper for the motor ramp.
// ----------------------------------------------------------------------------
package rmpr_pkg;

  localparam int DUTY_W  = 8;
  localparam int SPEED_W = 8;
  localparam int DIV_W   = 16;
  localparam int STEP_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DUTY_W-1:0] DUTY_STOP_CW  = '0;
  localparam logic [DUTY_W-1:0] DUTY_STOP_CCW = '1;

  localparam logic [DIV_W-1:0]  TICK_DIVIDE_RST = 16'd160;
  localparam logic [STEP_W-1:0] STEP_SIZE_RST   = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_DIVIDE = 2'd0,
    REG_STEP_SIZE   = 2'd1
  } cfg_reg_t;

  localparam logic DIR_CW  = 1'b1;
  localparam logic DIR_CCW = 1'b0;

  // Move duty toward goal by at most step, landing exactly on goal.
  function automatic logic [DUTY_W-1:0] move_toward(
    input logic [DUTY_W-1:0] duty,
    input logic [DUTY_W-1:0] goal,
    input logic [STEP_W-1:0] step
  );
    logic [DUTY_W-1:0] res;
    res = duty;
    if (duty < goal) begin
      res = ((goal - duty) > step) ? duty + step : goal;
    end else if (duty > goal) begin
      res = ((duty - goal) > step) ? duty - step : goal;
    end
    return res;
  endfunction

endpackage

// ----- src/rmpr_cmd_if.sv -----
// ----------------------------------------------------------------------------
// rmpr_cmd_if
// Control pass channel: wanted direction and speed.
// ----------------------------------------------------------------------------
interface rmpr_cmd_if import rmpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               target_direction;
  logic [SPEED_W-1:0] target_speed;

  modport source (output valid, target_direction, target_speed, input ready);
  modport sink   (input valid, target_direction, target_speed, output ready);
endinterface

// ----- src/rmpr_out_if.sv -----
// ----------------------------------------------------------------------------
// rmpr_out_if
// Result channel: duty, reverse pin level and step flag.
// ----------------------------------------------------------------------------
interface rmpr_out_if import rmpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] pwm_duty;
  logic              reverse_pin;
  logic              ramp_stepped;

  modport source (output valid, pwm_duty, reverse_pin, ramp_stepped, input ready);
  modport sink   (input valid, pwm_duty, reverse_pin, ramp_stepped, output ready);
endinterface

// ----- src/rmpr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rmpr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rmpr_cfg_if import rmpr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/reversing_motor_pwm_ramp.sv -----
// ----------------------------------------------------------------------------
// reversing_motor_pwm_ramp
// Accepted passes are registered in the input stage, then the result stage;
// one item per cycle unless result.ready stalls. The ramp update is combinational.
// Sync active-high rst: tick_divide 160, step_size 5, pass count 0,
// clockwise, duty 0, both pipeline stages empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module reversing_motor_pwm_ramp import rmpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rmpr_cfg_if.sink    cfg,
  rmpr_cmd_if.sink    cmd,
  rmpr_out_if.source  result
);

  // Configuration registers
  logic [DIV_W-1:0]  tick_divide;
  logic [STEP_W-1:0] step_size;

  // Ramp state
  logic [DIV_W-1:0]  pass_count;
  logic              run_dir;
  logic [DUTY_W-1:0] duty_now;

  // Input stage
  logic               s1_valid;
  logic               s1_dir;
  logic [SPEED_W-1:0] s1_speed;

  // Result stage
  logic              out_valid;
  logic [DUTY_W-1:0] out_duty;
  logic              out_rev;
  logic              out_stepped;

  // Handshake: result stage frees when empty or being taken; input stage
  // frees when empty or moving into the result stage.
  logic s1_adv;
  logic out_free;
  assign out_free  = !out_valid || result.ready;
  assign s1_adv    = s1_valid && out_free;
  assign cmd.ready = !s1_valid || out_free;
  assign cfg.ready = 1'b1;

  assign result.valid        = out_valid;
  assign result.pwm_duty     = out_duty;
  assign result.reverse_pin  = out_rev;
  assign result.ramp_stepped = out_stepped;

  // Ramp update for the pass in the input stage
  logic [DIV_W:0]    pass_inc;
  logic [DIV_W:0]    divide_eff;
  logic              step_hit;
  logic [DIV_W-1:0]  pass_count_next;
  logic              run_dir_next;
  logic [DUTY_W-1:0] duty_next;

  always_comb begin
    pass_inc   = {1'b0, pass_count} + {{DIV_W{1'b0}}, 1'b1};
    // divide of zero behaves as one
    divide_eff = (tick_divide == '0) ? {{DIV_W{1'b0}}, 1'b1} : {1'b0, tick_divide};
    step_hit   = (pass_inc >= divide_eff);
    pass_count_next = step_hit ? '0 : pass_inc[DIV_W-1:0];

    run_dir_next = run_dir;
    duty_next    = duty_now;
    if (step_hit) begin
      if (run_dir == DIR_CW) begin
        if (s1_dir == DIR_CCW) begin
          // slow to stop, then flip to the stopped value of the new direction
          if (duty_now != DUTY_STOP_CW) begin
            duty_next = move_toward(duty_now, DUTY_STOP_CW, step_size);
          end else begin
            run_dir_next = DIR_CCW;
            duty_next    = DUTY_STOP_CCW;
          end
        end else begin
          duty_next = move_toward(duty_now, s1_speed, step_size);
        end
      end else begin
        if (s1_dir == DIR_CW) begin
          if (duty_now != DUTY_STOP_CCW) begin
            duty_next = move_toward(duty_now, DUTY_STOP_CCW, step_size);
          end else begin
            run_dir_next = DIR_CW;
            duty_next    = DUTY_STOP_CW;
          end
        end else begin
          // reverse running drives the inverted duty
          duty_next = move_toward(duty_now, DUTY_STOP_CCW - s1_speed, step_size);
        end
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divide <= TICK_DIVIDE_RST;
      step_size   <= STEP_SIZE_RST;
      pass_count  <= '0;
      run_dir     <= DIR_CW;
      duty_now    <= DUTY_STOP_CW;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_TICK_DIVIDE: tick_divide <= cfg.data[DIV_W-1:0];
          REG_STEP_SIZE:   step_size   <= cfg.data[STEP_W-1:0];
          default: ; // unknown index ignored
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        pass_count <= pass_count_next;
        run_dir    <= run_dir_next;
        duty_now   <= duty_next;
        out_valid  <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_dir   <= cmd.target_direction;
      s1_speed <= cmd.target_speed;
    end
    if (s1_adv) begin
      out_duty    <= duty_next;
      out_rev     <= (run_dir_next == DIR_CCW);
      out_stepped <= step_hit;
    end
  end

  // A direction flip always lands on the stopped value of the new direction.
  `ASSERT_IMPLY(a_flip_at_stop, clk, rst, !$stable(run_dir),
    (run_dir == DIR_CW && duty_now == DUTY_STOP_CW) ||
    (run_dir == DIR_CCW && duty_now == DUTY_STOP_CCW))
  // A stepping pass restarts the pass counter.
  `ASSERT_NEXT(a_count_restart, clk, rst, s1_adv && step_hit, pass_count == '0)
  // A full input stage behind a stalled result blocks new items.
  `ASSERT_IMPLY(a_stall_blocks, clk, rst, s1_valid && out_valid && !result.ready,
    !cmd.ready)

endmodule

// ----- tb/reversing_motor_pwm_ramp_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reversing_motor_pwm_ramp_tb
// Self-checking bench for the reversing PWM ramp. A scoreboard class keeps
// its own copy of the ramp state, predicts duty, reverse pin and step flag
// for every accepted pass, and checks the results in order. Directed passes
// cover the special cases. Random passes then run in stretches that hold one
// target for a while and mix in noise. Both sides stall at random.
// ----------------------------------------------------------------------------
module reversing_motor_pwm_ramp_tb;
  import rmpr_pkg::*;

  // Indexes the block has no register behind; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int LONG_HOLD   = 60;  // receiver stall, in cycles
  localparam int MAX_REPORTS = 10;
  localparam int SEG_PASSES  = 100; // random passes per config setting

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              reverse;
    logic              stepped;
  } ramp_out_t;

  // --------------------------------------------------------------------------
  // Ramp scoreboard: private copy of the registers and ramp state, plus the
  // queue of results still owed by the block.
  // --------------------------------------------------------------------------
  class ramp_scoreboard;
    logic [DIV_W-1:0]  tick_div;
    logic [STEP_W-1:0] step_amt;
    logic [DIV_W-1:0]  pass_cnt;
    logic              run_dir;
    logic [DUTY_W-1:0] duty;
    ramp_out_t         owed_q[$];
    int                mismatches;

    function void reset_state();
      tick_div   = TICK_DIVIDE_RST;
      step_amt   = STEP_SIZE_RST;
      pass_cnt   = '0;
      run_dir    = DIR_CW;
      duty       = DUTY_STOP_CW;
      mismatches = 0;
      owed_q.delete();
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TICK_DIVIDE: tick_div = data[DIV_W-1:0];
        REG_STEP_SIZE:   step_amt = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // Slew duty toward goal, never overshooting it.
    function logic [DUTY_W-1:0] slew(logic [DUTY_W-1:0] cur, logic [DUTY_W-1:0] goal);
      int gap;
      gap = int'(goal) - int'(cur);
      if (gap > int'(step_amt)) return cur + step_amt;
      if (-gap > int'(step_amt)) return cur - step_amt;
      return goal;
    endfunction

    // One ramp step. Reversal: ramp to the stop value of the running
    // direction, then flip and restart from the stop value of the new one.
    function void ramp_step(logic want_dir, logic [SPEED_W-1:0] speed);
      if (run_dir == DIR_CW) begin
        if (want_dir == DIR_CCW) begin
          if (duty != DUTY_STOP_CW) duty = slew(duty, DUTY_STOP_CW);
          else begin
            run_dir = DIR_CCW;
            duty    = DUTY_STOP_CCW;
          end
        end else begin
          duty = slew(duty, speed);
        end
      end else begin
        if (want_dir == DIR_CW) begin
          if (duty != DUTY_STOP_CCW) duty = slew(duty, DUTY_STOP_CCW);
          else begin
            run_dir = DIR_CW;
            duty    = DUTY_STOP_CW;
          end
        end else begin
          duty = slew(duty, DUTY_STOP_CCW - speed);
        end
      end
    endfunction

    function void note_pass(logic want_dir, logic [SPEED_W-1:0] speed);
      logic [DIV_W:0] next_cnt;
      logic [DIV_W:0] divide;
      ramp_out_t      res;
      divide   = (tick_div == '0) ? {{DIV_W{1'b0}}, 1'b1} : {1'b0, tick_div};
      next_cnt = {1'b0, pass_cnt} + {{DIV_W{1'b0}}, 1'b1};
      res.stepped = 1'b0;
      // >= so that lowering the divide below the count steps right away
      if (next_cnt >= divide) begin
        pass_cnt    = '0;
        res.stepped = 1'b1;
        ramp_step(want_dir, speed);
      end else begin
        pass_cnt = next_cnt[DIV_W-1:0];
      end
      res.duty    = duty;
      res.reverse = (run_dir == DIR_CCW);
      owed_q.push_back(res);
    endfunction

    function void check_result(ramp_out_t got);
      ramp_out_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result duty %0d rev %0b step %0b",
                   $realtime, got.duty, got.reverse, got.stepped);
        return;
      end
      want = owed_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result error: duty exp %0d got %0d, ",
                   $realtime, want.duty, got.duty,
                   "rev exp %0b got %0b, step exp %0b got %0b",
                   want.reverse, got.reverse, want.stepped, got.stepped);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rmpr_cfg_if cfg_bus ();
  rmpr_cmd_if cmd_bus ();
  rmpr_out_if res_bus ();

  reversing_motor_pwm_ramp DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .cmd    (cmd_bus),
    .result (res_bus)
  );

  ramp_scoreboard sb;

  // Idle rates in percent, set per phase by the main process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Long-stall requests: main bumps hold_req_n, receiver does the counting.
  int hold_req_n = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous limit: far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge. A pending hold request
  // drops ready for the LONG_HOLD stall so the pipeline backs up into cmd.
  // --------------------------------------------------------------------------
  initial begin
    int hold_ack_n;
    int hold_left;
    hold_ack_n    = 0;
    hold_left     = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ack_n != hold_req_n) begin
        hold_ack_n = hold_req_n;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        res_bus.ready = 1'b0;
        hold_left--;
      end else begin
        res_bus.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Results are taken at the rising edge, as the block sees the handshake.
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready)
      sb.check_result({res_bus.pwm_duty, res_bus.reverse_pin, res_bus.ramp_stepped});
  end

  // One control pass; may idle first. Valid stays high after acceptance so
  // back-to-back items follow without a gap.
  task automatic send_pass(input logic dir, input logic [SPEED_W-1:0] speed);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid = 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid            = 1'b1;
    cmd_bus.target_direction = dir;
    cmd_bus.target_speed     = speed;
    do @(posedge clk); while (!cmd_bus.ready);
    sb.note_pass(dir, speed);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Stop offering and wait for every owed result; every pass yields one,
  // so the block is idle once the queue is empty.
  task automatic drain();
    @(negedge clk);
    cmd_bus.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly held targets so ramps and reversals run to completion, with
  // about one pass in ten of random noise.
  task automatic run_traffic(input int n);
    int left;
    int run_len;
    logic dir;
    logic [SPEED_W-1:0] spd;
    left = n;
    while (left > 0) begin
      dir = 1'($urandom);
      case ($urandom_range(4))
        0:       spd = '0;
        1:       spd = '1;
        default: spd = SPEED_W'($urandom);
      endcase
      run_len = $urandom_range(1, 60);
      while (run_len > 0 && left > 0) begin
        if ($urandom_range(99) < 10) send_pass(1'($urandom), SPEED_W'($urandom));
        else send_pass(dir, spd);
        run_len--;
        left--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int r;
    logic [DIV_W-1:0]  div;
    logic [STEP_W-1:0] stp;

    rst                      = 1'b1;
    cfg_bus.valid            = 1'b0;
    cfg_bus.index            = REG_TICK_DIVIDE;
    cfg_bus.data             = '0;
    cmd_bus.valid            = 1'b0;
    cmd_bus.target_direction = DIR_CCW;
    cmd_bus.target_speed     = '0;
    sb = new();
    sb.reset_state();

    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // ---- directed ----
    // Reset divide of 160: no step, pass count just climbs.
    send_pass(DIR_CW, 8'd255);
    send_pass(DIR_CW, 8'd255);
    drain();

    // Divide 1 with the count above it: steps at once, reset step size of 5.
    cfg_write(REG_TICK_DIVIDE, 16'd1);
    send_pass(DIR_CW, 8'd255);
    send_pass(DIR_CW, 8'd255);
    drain();

    // Divide of zero acts as one; full step jumps straight to each target.
    // Upper data bits set to check the step register takes only its width.
    cfg_write(REG_TICK_DIVIDE, 16'd0);
    cfg_write(REG_STEP_SIZE, 16'hFFFF);
    send_pass(DIR_CW, 8'd255);   // full speed clockwise
    send_pass(DIR_CW, 8'd0);     // back to stop
    send_pass(DIR_CCW, 8'd0);    // at stop: flip, duty restarts at 255
    send_pass(DIR_CCW, 8'd255);  // inverted: full ccw speed is duty 0
    send_pass(DIR_CW, 8'd7);     // ramp to the ccw stop value first
    send_pass(DIR_CW, 8'd7);     // then flip back, duty 0
    send_pass(DIR_CW, 8'd0);     // hold at stop for the zero-step case
    drain();

    // Writes to indexes with no register must change nothing.
    cfg_write(REG_SPARE_2, 16'h0000);
    cfg_write(REG_SPARE_3, 16'hFFFF);

    // Step of zero: duty frozen, but a reversal from a stop still flips.
    cfg_write(REG_STEP_SIZE, 16'hAA00);
    send_pass(DIR_CW, 8'd200);
    send_pass(DIR_CCW, 8'd9);
    send_pass(DIR_CCW, 8'd0);
    send_pass(DIR_CW, 8'd3);
    drain();

    // Largest divide: count builds up with no step.
    cfg_write(REG_TICK_DIVIDE, 16'hFFFF);
    cfg_write(REG_STEP_SIZE, 16'h5501);
    run_traffic(6);
    drain();

    // Divide lowered below the count: next pass steps and the count restarts.
    cfg_write(REG_TICK_DIVIDE, 16'd3);
    send_pass(DIR_CW, 8'd3);
    send_pass(DIR_CW, 8'd3);
    send_pass(DIR_CW, 8'd3);
    send_pass(DIR_CW, 8'd3);

    // ---- random ----
    // Phase 0: sender idles little, receiver a lot. Phase 1: the reverse.
    // Phase 2: no idling at all.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        drain();
        r = $urandom_range(99);
        if (r < 8) div = '0;
        else if (r < 55) div = DIV_W'($urandom_range(1, 4));
        else if (r < 85) div = DIV_W'($urandom_range(5, 24));
        else if (r < 95) div = DIV_W'($urandom_range(25, 300));
        else div = DIV_W'($urandom_range(301, 65535));
        r = $urandom_range(99);
        if (r < 5) stp = '0;
        else if (r < 15) stp = '1;
        else if (r < 25) stp = 8'd1;
        else stp = STEP_W'($urandom_range(2, 40));
        // First setting of each phase pinned to the fast extremes.
        if (seg == 0) begin
          div = DIV_W'(ph);
          stp = (ph == 0) ? 8'd255 : 8'd1;
        end
        cfg_write(REG_TICK_DIVIDE, div);
        cfg_write(REG_STEP_SIZE, {8'($urandom), stp});
        if ($urandom_range(3) == 0)
          cfg_write($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
        // Long output stall while passes keep coming: fills the pipeline.
        if (seg == 1) hold_req_n++;
        run_traffic(SEG_PASSES);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
